// ===== rtl/core/pmdr_pkg.sv =====
package pmdr_pkg;

   // Input beat
   typedef struct packed {
      logic        op;
      logic        frame_start;
      logic [7:0]  stream_byte;
      logic [12:0] read_index;
   } req_type;

   // Result beat
   typedef struct packed {
      logic        kind;
      logic [3:0]  event_res;
      logic [13:0] group_length;
      logic        quality_valid;
      logic [6:0]  quality;
      logic [7:0]  read_byte;
   } rsp_type;

   // Command from front to back: a group read or a finished packet
   typedef struct packed {
      logic        is_read;
      logic [12:0] read_index;
      logic        crc_ok;
      logic [1:0]  flags;
      logic [9:0]  address;
      logic [6:0]  useful;
      logic        bank;
   } cmd_type;

   // Packet byte write into the payload banks
   typedef struct packed {
      logic       en;
      logic       bank;
      logic [6:0] pos;
      logic [7:0] data;
   } pay_wr_type;

   // Payload bank handed back by the back part
   typedef struct packed {
      logic en;
      logic bank;
   } bank_rel_type;

   // Configuration register values
   typedef struct packed {
      logic [10:0] bit_rate;
      logic        disable_assembly;
      logic        report_quality;
   } cfg_type;

   localparam logic [1:0] CSR_BIT_RATE       = 2'd0;
   localparam logic [1:0] CSR_DISABLE_ASSY   = 2'd1;
   localparam logic [1:0] CSR_REPORT_QUALITY = 2'd2;

   localparam logic [3:0] EV_CRC_ERROR   = 4'd0;
   localparam logic [3:0] EV_PADDING     = 4'd1;
   localparam logic [3:0] EV_FOREIGN     = 4'd2;
   localparam logic [3:0] EV_STARTED     = 4'd3;
   localparam logic [3:0] EV_APPENDED    = 4'd4;
   localparam logic [3:0] EV_COMPLETED   = 4'd5;
   localparam logic [3:0] EV_DISCARDED   = 4'd6;
   localparam logic [3:0] EV_IGNORED     = 4'd7;
   localparam logic [3:0] EV_OVERFLOW    = 4'd8;
   localparam logic [3:0] EV_NOT_ASSY    = 4'd9;

   localparam logic [1:0] FL_CONT   = 2'd0;
   localparam logic [1:0] FL_LAST   = 2'd1;
   localparam logic [1:0] FL_FIRST  = 2'd2;
   localparam logic [1:0] FL_SINGLE = 2'd3;

   localparam logic       KIND_REPORT = 1'b0;
   localparam logic       KIND_READ   = 1'b1;

   localparam logic [11:0] FRAME_MAX     = 12'd4095;
   localparam logic [8:0]  QUAL_PERIOD   = 9'd500;
   localparam logic [8:0]  FAIL_MAX      = 9'd511;
   localparam logic [6:0]  QUAL_FULL     = 7'd100;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   // CRC-16 CCITT over one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/packet_mode_datagroup_reassembler.sv =====
// Packet mode data group reassembler.
// Stream bytes and reads are taken one per cycle unless the command queue is full
// or the payload bank to be filled is still being copied.
// Back part: a packet end passes through S_COPY, which copies its useful bytes (one byte
// per cycle), a read through S_READ; results come out of a one-entry output register.
// Synchronous active-high reset clears all control state; stores are not cleared.
module packet_mode_datagroup_reassembler
   import pmdr_pkg::*;
#(
   parameter int GROUP_BYTES   = 8192,
   parameter int PAYLOAD_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_push, q_full, q_pop, q_valid, rsp_valid;
   cmd_type      q_in_data, q_out_data;
   pay_wr_type   pay_wr;
   bank_rel_type bank_rel;

   assign csr_ready = 1'b1;
   assign empty     = ~rsp_valid;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BIT_RATE:       cfg_in.bit_rate         = csr_data;
            CSR_DISABLE_ASSY:   cfg_in.disable_assembly = csr_data[0];
            CSR_REPORT_QUALITY: cfg_in.report_quality   = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_rate         <= 11'd8;
         cfg_ff.disable_assembly <= 1'b0;
         cfg_ff.report_quality   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pmdr_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req      (req_data),
      .cmd_push (q_push),
      .cmd      (q_in_data),
      .cmd_full (q_full),
      .pay_wr   (pay_wr),
      .bank_rel (bank_rel)
   );

   pmdr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out_data)
   );

   pmdr_back #(.GROUP_BYTES(GROUP_BYTES), .PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (q_valid),
      .cmd       (q_out_data),
      .cmd_pop   (q_pop),
      .pay_wr    (pay_wr),
      .bank_rel  (bank_rel),
      .rsp_valid (rsp_valid),
      .rsp_taken (pop),
      .rsp       (rsp_data)
   );

endmodule

// ===== rtl/core/pmdr_front.sv =====
module pmdr_front
   import pmdr_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         push,
   output logic         full,
   input  req_type      req,
   output logic         cmd_push,
   output cmd_type      cmd,
   input  logic         cmd_full,
   output pay_wr_type   pay_wr,
   input  bank_rel_type bank_rel
);

   logic [11:0] frame_left_ff, frame_left_in;
   logic [6:0]  pos_ff, pos_in;
   logic [6:0]  plen_ff, plen_in;
   logic [23:0] hdr_ff, hdr_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  prev_ff, prev_in;
   logic        bank_ff, bank_in;
   logic [1:0]  busy_ff, busy_in;

   logic        accept;
   logic [12:0] frame_size;
   logic [11:0] left_e;
   logic [6:0]  pos_e, plen_e, plen_first, pos_n, useful_max;
   logic [23:0] hdr_e, hdr_n;
   logic [15:0] crc_e;
   logic        packet_end;

   // Stall while the queue is full or the bank we fill is still being copied
   assign full   = cmd_full | busy_ff[bank_ff];
   assign accept = push & ~full;

   assign frame_size = 13'(3 * cfg.bit_rate);
   assign plen_first = 7'((3'({1'b0, req.stream_byte[7:6]}) + 3'd1) * 7'd24);

   always_comb begin
      frame_left_in = frame_left_ff;
      pos_in        = pos_ff;
      plen_in       = plen_ff;
      hdr_in        = hdr_ff;
      crc_in        = crc_ff;
      prev_in       = prev_ff;
      bank_in       = bank_ff;
      cmd_push      = 1'b0;
      cmd           = '0;
      pay_wr        = '0;
      packet_end    = 1'b0;
      left_e        = frame_left_ff;
      pos_e         = pos_ff;
      crc_e         = crc_ff;
      hdr_e         = hdr_ff;
      plen_e        = plen_ff;
      pos_n         = pos_ff;
      hdr_n         = hdr_ff;
      useful_max    = '0;
      if (accept && req.op) begin
         // Group read goes straight to the back
         cmd_push       = 1'b1;
         cmd.is_read    = 1'b1;
         cmd.read_index = req.read_index;
      end else if (accept) begin
         // Open a new frame
         if (req.frame_start) begin
            left_e = (frame_size > 13'(FRAME_MAX)) ? FRAME_MAX : frame_size[11:0];
            pos_e  = '0;
            crc_e  = CRC_INIT;
            hdr_e  = '0;
         end
         frame_left_in = left_e;
         pos_in        = pos_e;
         crc_in        = crc_e;
         hdr_in        = hdr_e;
         if (left_e != '0) begin
            plen_e = (pos_e == '0) ? plen_first : plen_ff;
            if (pos_e == '0 && 12'(plen_first) > left_e) begin
               // Packet does not fit: drop the rest of the frame
               frame_left_in = '0;
            end else begin
               frame_left_in = left_e - 12'd1;
               plen_in       = plen_e;
               pay_wr.en     = 1'b1;
               pay_wr.bank   = bank_ff;
               pay_wr.pos    = pos_e;
               pay_wr.data   = req.stream_byte;
               hdr_n = (pos_e < 7'd3) ? {hdr_e[15:0], req.stream_byte} : hdr_e;
               hdr_in = hdr_n;
               if (8'(pos_e) + 8'd2 < 8'(plen_e)) begin
                  crc_in = crc_byte(crc_e, req.stream_byte);
               end
               prev_in = req.stream_byte;
               pos_n   = pos_e + 7'd1;
               pos_in  = pos_n;
               if (pos_n == plen_e) begin
                  // Packet complete: hand it to the back
                  packet_end     = 1'b1;
                  useful_max     = plen_e - 7'd5;
                  cmd_push       = 1'b1;
                  cmd.is_read    = 1'b0;
                  cmd.crc_ok     = ((crc_e ^ CRC_INIT) == {prev_ff, req.stream_byte});
                  cmd.flags      = hdr_n[19:18];
                  cmd.address    = hdr_n[17:8];
                  cmd.useful     = (hdr_n[6:0] > useful_max) ? useful_max : hdr_n[6:0];
                  cmd.bank       = bank_ff;
                  pos_in         = '0;
                  crc_in         = CRC_INIT;
                  hdr_in         = '0;
                  bank_in        = ~bank_ff;
               end
            end
         end
      end
   end

   // Track which payload bank is owned by a queued packet
   always_comb begin
      busy_in = busy_ff;
      if (bank_rel.en) begin
         busy_in[bank_rel.bank] = 1'b0;
      end
      if (packet_end) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_left_ff <= '0;
         pos_ff        <= '0;
         plen_ff       <= '0;
         hdr_ff        <= '0;
         crc_ff        <= CRC_INIT;
         bank_ff       <= 1'b0;
         busy_ff       <= '0;
      end else begin
         frame_left_ff <= frame_left_in;
         pos_ff        <= pos_in;
         plen_ff       <= plen_in;
         hdr_ff        <= hdr_in;
         crc_ff        <= crc_in;
         bank_ff       <= bank_in;
         busy_ff       <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

   a_rel_busy: assert property (@(posedge clock) disable iff (reset)
      bank_rel.en |-> busy_ff[bank_rel.bank])
      else $error("released a payload bank that was not owned");

   a_pos_in_packet: assert property (@(posedge clock) disable iff (reset)
      pos_ff != '0 |-> pos_ff < plen_ff && 8'(plen_ff) <= 8'(PAYLOAD_BYTES))
      else $error("packet byte position outside packet");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into a full queue");

endmodule

// ===== rtl/core/pmdr_cmd_queue.sv =====
module pmdr_cmd_queue
   import pmdr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/pmdr_back.sv =====
module pmdr_back
   import pmdr_pkg::*;
#(
   parameter int GROUP_BYTES   = 8192,
   parameter int PAYLOAD_BYTES = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   input  pay_wr_type   pay_wr,
   output bank_rel_type bank_rel,
   output logic         rsp_valid,
   input  logic         rsp_taken,
   output rsp_type      rsp
);

   localparam int GAW = $clog2(GROUP_BYTES);
   localparam int GBW = $clog2(GROUP_BYTES + 1);
   localparam int PAW = $clog2(2 * PAYLOAD_BYTES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_COPY = 3'b010,
      S_READ = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] pay_mem   [2 * PAYLOAD_BYTES];
   logic [7:0] group_mem [GROUP_BYTES];

   logic           in_group_ff, in_group_in;
   logic           locked_ff, locked_in;
   logic [9:0]     lock_addr_ff, lock_addr_in;
   logic [GBW-1:0] gb_ff, gb_in;
   logic [8:0]     seen_ff, seen_in;
   logic [8:0]     fail_ff, fail_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [6:0]     idx_ff, idx_in;
   logic           bank_ff, bank_in;
   logic [3:0]     ev_ff, ev_in;
   logic           qv_ff, qv_in;
   logic [6:0]     q_ff, q_in;
   logic           wr_v_ff, wr_v_in;
   logic           in_range_ff, in_range_in;
   logic           rsp_v_ff, rsp_v_in;
   rsp_type        rsp_ff, rsp_in;
   logic [7:0]     pay_rd_ff;
   logic [7:0]     grp_rd_ff;

   logic           slot_free, emit, pay_rd_en, grp_rd_en;
   logic [PAW-1:0] pay_rd_addr;
   logic [GAW-1:0] grp_rd_addr;
   logic [8:0]     seen_n, fail_base;
   logic [16:0]    lost_prod;
   logic [7:0]     lost;
   logic [9:0]     lock_e;

   assign slot_free = ~rsp_v_ff | rsp_taken;
   assign rsp_valid = rsp_v_ff;
   assign rsp       = rsp_ff;

   // Loss over the window: fail count divided by five
   assign seen_n    = seen_ff + 9'd1;
   assign lost_prod = 17'(fail_ff) * 17'd205;
   assign lost      = 8'(lost_prod >> 10);

   always_comb begin
      state_in    = state_ff;
      in_group_in = in_group_ff;
      locked_in   = locked_ff;
      lock_addr_in = lock_addr_ff;
      gb_in       = gb_ff;
      seen_in     = seen_ff;
      fail_in     = fail_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      bank_in     = bank_ff;
      ev_in       = ev_ff;
      qv_in       = qv_ff;
      q_in        = q_ff;
      wr_v_in     = 1'b0;
      in_range_in = in_range_ff;
      rsp_v_in    = rsp_v_ff & ~rsp_taken;
      rsp_in      = rsp_ff;
      cmd_pop     = 1'b0;
      bank_rel    = '0;
      emit        = 1'b0;
      pay_rd_en   = 1'b0;
      pay_rd_addr = '0;
      grp_rd_en   = 1'b0;
      grp_rd_addr = '0;
      fail_base   = fail_ff;
      lock_e      = lock_addr_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               if (cmd.is_read) begin
                  // Start a registered group store read
                  grp_rd_en   = 1'b1;
                  grp_rd_addr = GAW'(cmd.read_index);
                  in_range_in = (GBW'(cmd.read_index) < gb_ff) &&
                                (32'(cmd.read_index) < GROUP_BYTES);
                  state_in    = S_READ;
               end else begin
                  qv_in   = 1'b0;
                  q_in    = '0;
                  cnt_in  = '0;
                  idx_in  = '0;
                  bank_in = cmd.bank;
                  if (cfg.disable_assembly) begin
                     ev_in = cmd.crc_ok ? EV_NOT_ASSY : EV_CRC_ERROR;
                  end else begin
                     // Quality window
                     if (cfg.report_quality) begin
                        if (seen_n >= QUAL_PERIOD) begin
                           qv_in     = 1'b1;
                           q_in      = (lost >= 8'(QUAL_FULL)) ? 7'd0 :
                                       (QUAL_FULL - 7'(lost));
                           seen_in   = '0;
                           fail_base = '0;
                        end else begin
                           seen_in = seen_n;
                        end
                     end
                     fail_in = fail_base;
                     if (!cmd.crc_ok) begin
                        if (fail_base < FAIL_MAX) begin
                           fail_in = fail_base + 9'd1;
                        end
                        ev_in = EV_CRC_ERROR;
                     end else if (cmd.address == '0) begin
                        ev_in = EV_PADDING;
                     end else begin
                        if (!locked_ff) begin
                           locked_in    = 1'b1;
                           lock_addr_in = cmd.address;
                           lock_e       = cmd.address;
                        end
                        if (cmd.address != lock_e) begin
                           ev_in = EV_FOREIGN;
                        end else if (cmd.flags == FL_FIRST) begin
                           in_group_in = 1'b1;
                           gb_in       = '0;
                           cnt_in      = cmd.useful;
                           ev_in       = EV_STARTED;
                        end else if (!in_group_ff) begin
                           gb_in = '0;
                           if (cmd.flags == FL_SINGLE) begin
                              cnt_in = cmd.useful;
                              ev_in  = EV_COMPLETED;
                           end else begin
                              ev_in  = EV_IGNORED;
                           end
                        end else if (cmd.flags == FL_SINGLE) begin
                           in_group_in = 1'b0;
                           gb_in       = '0;
                           ev_in       = EV_DISCARDED;
                        end else if (32'(gb_ff) + 32'(cmd.useful) > GROUP_BYTES) begin
                           in_group_in = 1'b0;
                           gb_in       = '0;
                           ev_in       = EV_OVERFLOW;
                        end else begin
                           cnt_in = cmd.useful;
                           if (cmd.flags == FL_LAST) begin
                              in_group_in = 1'b0;
                              ev_in       = EV_COMPLETED;
                           end else begin
                              ev_in       = EV_APPENDED;
                           end
                        end
                     end
                  end
                  state_in = S_COPY;
               end
            end
         end
         S_COPY: begin
            // Issue payload reads, write each byte to the group store in the following cycle
            if (wr_v_ff) begin
               gb_in = gb_ff + GBW'(1);
            end
            if (idx_ff < cnt_ff) begin
               pay_rd_en   = 1'b1;
               pay_rd_addr = PAW'(32'(bank_ff) * PAYLOAD_BYTES + 32'(idx_ff) + 3);
               idx_in      = idx_ff + 7'd1;
               wr_v_in     = 1'b1;
            end else if (!wr_v_ff) begin
               emit                  = 1'b1;
               bank_rel.en           = 1'b1;
               bank_rel.bank         = bank_ff;
               rsp_v_in              = 1'b1;
               rsp_in.kind           = KIND_REPORT;
               rsp_in.event_res      = ev_ff;
               rsp_in.group_length   = 14'(gb_ff);
               rsp_in.quality_valid  = qv_ff;
               rsp_in.quality        = q_ff;
               rsp_in.read_byte      = '0;
               state_in              = S_IDLE;
            end
         end
         S_READ: begin
            emit                  = 1'b1;
            rsp_v_in              = 1'b1;
            rsp_in.kind           = KIND_READ;
            rsp_in.event_res      = EV_CRC_ERROR;
            rsp_in.group_length   = 14'(gb_ff);
            rsp_in.quality_valid  = 1'b0;
            rsp_in.quality        = '0;
            rsp_in.read_byte      = in_range_ff ? grp_rd_ff : 8'd0;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_group_ff  <= 1'b0;
         locked_ff    <= 1'b0;
         lock_addr_ff <= '0;
         gb_ff        <= '0;
         seen_ff      <= '0;
         fail_ff      <= '0;
         wr_v_ff      <= 1'b0;
         rsp_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_group_ff  <= in_group_in;
         locked_ff    <= locked_in;
         lock_addr_ff <= lock_addr_in;
         gb_ff        <= gb_in;
         seen_ff      <= seen_in;
         fail_ff      <= fail_in;
         wr_v_ff      <= wr_v_in;
         rsp_v_ff     <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      bank_ff     <= bank_in;
      ev_ff       <= ev_in;
      qv_ff       <= qv_in;
      q_ff        <= q_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

   // Payload banks: written by the front, read by the copier
   always_ff @(posedge clock) begin
      if (pay_wr.en) begin
         pay_mem[PAW'(32'(pay_wr.bank) * PAYLOAD_BYTES + 32'(pay_wr.pos))] <= pay_wr.data;
      end
      if (pay_rd_en) begin
         pay_rd_ff <= pay_mem[pay_rd_addr];
      end
   end

   // Group store
   always_ff @(posedge clock) begin
      if (wr_v_ff) begin
         group_mem[GAW'(gb_ff)] <= pay_rd_ff;
      end
      if (grp_rd_en) begin
         grp_rd_ff <= group_mem[grp_rd_addr];
      end
   end

   a_gb_bound: assert property (@(posedge clock) disable iff (reset)
      32'(gb_ff) <= GROUP_BYTES)
      else $error("group byte count beyond store");

   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> idx_ff <= cnt_ff)
      else $error("copy ran past its byte count");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("result produced over a waiting result");

endmodule
